[sv/oro_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and defaults of the ordered retry outbox.
package oro_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int MAX_CLAIM_DEF = 16;
    localparam int CLAIM_CAP     = 16;
    localparam int SHIFT_LIMIT   = 20;

    localparam logic [3:0] OP_ENQUEUE  = 4'd0;
    localparam logic [3:0] OP_CLAIM    = 4'd1;
    localparam logic [3:0] OP_ACK      = 4'd2;
    localparam logic [3:0] OP_APPLY    = 4'd3;
    localparam logic [3:0] OP_RETRY    = 4'd4;
    localparam logic [3:0] OP_CONFLICT = 4'd5;
    localparam logic [3:0] OP_FAIL     = 4'd6;
    localparam logic [3:0] OP_RESEND   = 4'd7;
    localparam logic [3:0] OP_DISCARD  = 4'd8;
    localparam logic [3:0] OP_RECOVER  = 4'd9;
    localparam logic [3:0] OP_PRUNE    = 4'd10;
    localparam logic [3:0] OP_LOOKUP   = 4'd11;

    localparam logic [2:0] RS_OK        = 3'd0;
    localparam logic [2:0] RS_QUEUED    = 3'd1;
    localparam logic [2:0] RS_BAD_ARG   = 3'd2;
    localparam logic [2:0] RS_NOT_FOUND = 3'd3;
    localparam logic [2:0] RS_WRONG     = 3'd4;
    localparam logic [2:0] RS_FULL      = 3'd5;
    localparam logic [2:0] RS_NONE      = 3'd6;

    localparam logic [2:0] ES_PENDING  = 3'd0;
    localparam logic [2:0] ES_INFLIGHT = 3'd1;
    localparam logic [2:0] ES_ACKED    = 3'd2;
    localparam logic [2:0] ES_APPLIED  = 3'd3;
    localparam logic [2:0] ES_CONFLICT = 3'd4;
    localparam logic [2:0] ES_FAILED   = 3'd5;

    localparam logic [2:0] CFG_ATTEMPT_LIMIT = 3'd0;
    localparam logic [2:0] CFG_FIRST_BACKOFF = 3'd1;
    localparam logic [2:0] CFG_BACKOFF_CAP   = 3'd2;
    localparam logic [2:0] CFG_BATCH_MIN     = 3'd3;
    localparam logic [2:0] CFG_BATCH_MAX     = 3'd4;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] key;
        logic [31:0] record;
        logic [47:0] now;
        logic [7:0]  batch;
        logic [47:0] sequence_req;
        logic [47:0] cutoff;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] entry_key;
        logic [31:0] entry_record;
        logic [2:0]  entry_state;
        logic [7:0]  entry_attempts;
        logic [47:0] entry_sequence;
        logic [47:0] entry_due;
        logic [4:0]  affected_count;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] record;
        logic [2:0]  state;
        logic [31:0] order;
        logic [47:0] due;
        logic [47:0] updated;
        logic [7:0]  tries;
        logic [47:0] seq;
    } ent_t;

endpackage

[sv/ordered_retry_outbox.sv]
`timescale 1ns / 1ps
// Ordered retry outbox: entry table, operation sequencer and result register.
// The block takes one operation word at a time and is not ready while it works on it.
// All entry fields but the valid flags live in one RAM with a single registered read
// port, so every operation that touches the table makes a pass over all its entries.
// Enqueue, the keyed operations, recover and prune load their result word after that
// pass, and a retry first doubles its backoff, capped, before it loads its result.
// Claim walks the table in enqueue order, ties going to the lower slot; each step of
// the walk is one pass to find the next entry and, for a due pending entry, one more
// pass to check its record for blocking, after which an unblocked entry is claimed.
// A result word is loaded only once the output register is free, and the block is
// ready again as soon as the last result word of an operation is loaded. A finished
// result word waits in the output register while the next operation word is accepted.
module ordered_retry_outbox #(
    parameter int ENTRIES   = oro_pkg::ENTRIES_DEF,
    parameter int MAX_CLAIM = oro_pkg::MAX_CLAIM_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  oro_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output oro_pkg::out_t m_data,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_wr_data
);
    import oro_pkg::*;

    localparam int IW        = $clog2(ENTRIES);
    localparam int CAP_A     = (MAX_CLAIM < CLAIM_CAP) ? MAX_CLAIM : CLAIM_CAP;
    localparam int LIMIT_CAP = (CAP_A < ENTRIES) ? CAP_A : ENTRIES;
    localparam int NW        = $clog2(LIMIT_CAP + 1);
    localparam int EW        = $bits(ent_t);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_KEYSCAN, S_KEYOP, S_BACKOFF, S_ENQSCAN, S_ENQWRITE,
        S_SWEEP, S_FIND, S_BLOCK, S_CLAIM, S_CDONE, S_RESP
    } state_t;

    state_t        state_reg, state_next;
    in_t           req_reg, req_next;
    logic [7:0]    attempt_limit_reg, attempt_limit_next;
    logic [31:0]   first_backoff_reg, first_backoff_next;
    logic [31:0]   backoff_cap_reg, backoff_cap_next;
    logic [4:0]    batch_min_reg, batch_min_next;
    logic [4:0]    batch_max_reg, batch_max_next;
    logic [31:0]   order_ctr_reg, order_ctr_next;
    logic          valid_reg [ENTRIES];
    logic          valid_next [ENTRIES];
    logic          scan_on_reg, scan_on_next;
    logic [IW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] slot_reg, slot_next;
    ent_t          ent_reg, ent_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          prev_found_reg, prev_found_next;
    logic [31:0]   prev_order_reg, prev_order_next;
    logic [IW-1:0] prev_idx_reg, prev_idx_next;
    logic          blocked_reg, blocked_next;
    logic [NW-1:0] claim_cnt_reg, claim_cnt_next;
    logic [NW-1:0] limit_reg, limit_next;
    out_t          held_reg, held_next;
    logic [4:0]    count_reg, count_next;
    logic [31:0]   bo_reg, bo_next;
    logic [4:0]    bo_cnt_reg, bo_cnt_next;
    out_t          resp_reg, resp_next;
    logic          m_valid_reg, m_valid_next;
    out_t          m_data_reg, m_data_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    oro_ram #(
        .WIDTH(EW),
        .DEPTH(ENTRIES)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    function automatic logic precedes(input logic [31:0] ao, input logic [IW-1:0] ai,
                                      input logic [31:0] bo, input logic [IW-1:0] bi);
        if (ao != bo) begin
            return ao < bo;
        end
        return ai < bi;
    endfunction

    function automatic out_t make_out(input logic [2:0] st, input ent_t e, input logic lst);
        out_t o;
        o = '0;
        o.status         = st;
        o.entry_key      = e.key;
        o.entry_record   = e.record;
        o.entry_state    = e.state;
        o.entry_attempts = e.tries;
        o.entry_sequence = e.seq;
        o.entry_due      = e.due;
        o.last           = lst;
        return o;
    endfunction

    function automatic out_t plain_out(input logic [2:0] st, input logic [4:0] cnt);
        out_t o;
        o = '0;
        o.status         = st;
        o.affected_count = cnt;
        o.last           = 1'b1;
        return o;
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        ent_t          rd_ent;
        ent_t          e;
        logic          rd_v;
        logic          scan_last;
        logic          out_free;
        logic          f;
        logic [IW-1:0] sl;
        ent_t          en;
        logic          blk;
        logic [4:0]    cnt;
        logic [32:0]   dbl;
        logic [48:0]   sum;

        state_next         = state_reg;
        req_next           = req_reg;
        attempt_limit_next = attempt_limit_reg;
        first_backoff_next = first_backoff_reg;
        backoff_cap_next   = backoff_cap_reg;
        batch_min_next     = batch_min_reg;
        batch_max_next     = batch_max_reg;
        order_ctr_next     = order_ctr_reg;
        valid_next         = valid_reg;
        scan_on_next       = scan_on_reg;
        scan_cnt_next      = scan_cnt_reg;
        rd_pend_next       = 1'b0;
        rd_idx_next        = rd_idx_reg;
        found_next         = found_reg;
        slot_next          = slot_reg;
        ent_next           = ent_reg;
        free_found_next    = free_found_reg;
        free_idx_next      = free_idx_reg;
        prev_found_next    = prev_found_reg;
        prev_order_next    = prev_order_reg;
        prev_idx_next      = prev_idx_reg;
        blocked_next       = blocked_reg;
        claim_cnt_next     = claim_cnt_reg;
        limit_next         = limit_reg;
        held_next          = held_reg;
        count_next         = count_reg;
        bo_next            = bo_reg;
        bo_cnt_next        = bo_cnt_reg;
        resp_next          = resp_reg;
        m_data_next        = m_data_reg;
        ram_we             = 1'b0;
        ram_waddr          = slot_reg;
        ram_wdata          = ent_reg;
        ram_raddr          = scan_cnt_reg;

        out_free     = !m_valid_reg || m_ready;
        m_valid_next = m_valid_reg && !m_ready;

        rd_ent    = ent_t'(ram_rdata);
        rd_v      = rd_pend_reg && valid_reg[rd_idx_reg];
        scan_last = rd_pend_reg && (rd_idx_reg == IW'(ENTRIES - 1));
        e         = ent_reg;
        f         = found_reg;
        sl        = slot_reg;
        en        = ent_reg;
        blk       = blocked_reg;
        cnt       = count_reg;
        dbl       = {bo_reg, 1'b0};
        sum       = {1'b0, req_reg.now} + {17'd0, bo_reg};

        if (scan_on_reg) begin
            rd_pend_next = 1'b1;
            rd_idx_next  = scan_cnt_reg;
            if (scan_cnt_reg == IW'(ENTRIES - 1)) begin
                scan_on_next = 1'b0;
            end else begin
                scan_cnt_next = scan_cnt_reg + IW'(1);
            end
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ATTEMPT_LIMIT: attempt_limit_next = cfg_wr_data[7:0];
                CFG_FIRST_BACKOFF: first_backoff_next = cfg_wr_data;
                CFG_BACKOFF_CAP:   backoff_cap_next   = cfg_wr_data;
                CFG_BATCH_MIN:     batch_min_next     = cfg_wr_data[4:0];
                CFG_BATCH_MAX:     batch_max_next     = cfg_wr_data[4:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                found_next      = 1'b0;
                free_found_next = 1'b0;
                count_next      = '0;
                unique case (req_reg.op)
                    OP_ENQUEUE: begin
                        if (req_reg.key == '0 || req_reg.record == '0) begin
                            resp_next  = plain_out(RS_BAD_ARG, '0);
                            state_next = S_RESP;
                        end else begin
                            scan_on_next  = 1'b1;
                            scan_cnt_next = '0;
                            state_next    = S_ENQSCAN;
                        end
                    end
                    OP_CLAIM: begin
                        limit_next = (req_reg.batch > 8'(LIMIT_CAP)) ? NW'(LIMIT_CAP)
                                                                      : NW'(req_reg.batch);
                        if (req_reg.batch < {3'd0, batch_min_reg}
                                || req_reg.batch > {3'd0, batch_max_reg}) begin
                            resp_next  = plain_out(RS_BAD_ARG, '0);
                            state_next = S_RESP;
                        end else if (req_reg.batch == '0) begin
                            resp_next  = plain_out(RS_NONE, '0);
                            state_next = S_RESP;
                        end else begin
                            claim_cnt_next  = '0;
                            prev_found_next = 1'b0;
                            scan_on_next    = 1'b1;
                            scan_cnt_next   = '0;
                            state_next      = S_FIND;
                        end
                    end
                    OP_RECOVER, OP_PRUNE: begin
                        scan_on_next  = 1'b1;
                        scan_cnt_next = '0;
                        state_next    = S_SWEEP;
                    end
                    OP_ACK, OP_APPLY, OP_RETRY, OP_CONFLICT, OP_FAIL, OP_RESEND,
                    OP_DISCARD, OP_LOOKUP: begin
                        if (req_reg.op == OP_APPLY && req_reg.sequence_req == '0) begin
                            resp_next  = plain_out(RS_BAD_ARG, '0);
                            state_next = S_RESP;
                        end else begin
                            scan_on_next  = 1'b1;
                            scan_cnt_next = '0;
                            state_next    = S_KEYSCAN;
                        end
                    end
                    default: begin
                        resp_next  = plain_out(RS_BAD_ARG, '0);
                        state_next = S_RESP;
                    end
                endcase
            end
            S_KEYSCAN: begin
                if (rd_v && !found_reg && rd_ent.key == req_reg.key) begin
                    found_next = 1'b1;
                    slot_next  = rd_idx_reg;
                    ent_next   = rd_ent;
                end
                if (scan_last) begin
                    state_next = S_KEYOP;
                end
            end
            S_KEYOP: begin
                e.updated  = req_reg.now;
                resp_next  = plain_out(RS_WRONG, '0);
                state_next = S_RESP;
                if (!found_reg) begin
                    resp_next = plain_out(RS_NOT_FOUND, '0);
                end else begin
                    unique case (req_reg.op)
                        OP_ACK: begin
                            if (ent_reg.state == ES_INFLIGHT) begin
                                e.state   = ES_ACKED;
                                ram_we    = 1'b1;
                                resp_next = plain_out(RS_OK, '0);
                            end
                        end
                        OP_APPLY: begin
                            if (ent_reg.state == ES_INFLIGHT || ent_reg.state == ES_ACKED) begin
                                e.state   = ES_APPLIED;
                                e.seq     = req_reg.sequence_req;
                                ram_we    = 1'b1;
                                resp_next = plain_out(RS_OK, '0);
                            end
                        end
                        OP_RETRY: begin
                            if (ent_reg.state == ES_INFLIGHT) begin
                                if (ent_reg.tries >= attempt_limit_reg) begin
                                    e.state   = ES_FAILED;
                                    ram_we    = 1'b1;
                                    resp_next = plain_out(RS_OK, '0);
                                end else begin
                                    bo_next     = first_backoff_reg;
                                    bo_cnt_next = '0;
                                    if (ent_reg.tries > 8'(SHIFT_LIMIT)) begin
                                        bo_next = backoff_cap_reg;
                                    end else if (ent_reg.tries > 8'd1) begin
                                        bo_cnt_next = 5'(ent_reg.tries - 8'd1);
                                    end
                                    state_next = S_BACKOFF;
                                end
                            end
                        end
                        OP_CONFLICT: begin
                            if (ent_reg.state == ES_INFLIGHT || ent_reg.state == ES_ACKED) begin
                                e.state   = ES_CONFLICT;
                                ram_we    = 1'b1;
                                resp_next = plain_out(RS_OK, '0);
                            end
                        end
                        OP_FAIL: begin
                            if (ent_reg.state != ES_APPLIED) begin
                                e.state   = ES_FAILED;
                                ram_we    = 1'b1;
                                resp_next = plain_out(RS_OK, '0);
                            end
                        end
                        OP_RESEND: begin
                            if (ent_reg.state != ES_APPLIED) begin
                                e.state   = ES_PENDING;
                                e.due     = req_reg.now;
                                ram_we    = 1'b1;
                                resp_next = plain_out(RS_OK, '0);
                            end
                        end
                        OP_DISCARD: begin
                            if (!(ent_reg.state == ES_PENDING && ent_reg.tries == '0)) begin
                                valid_next[slot_reg] = 1'b0;
                                resp_next = plain_out(RS_OK, '0);
                            end
                        end
                        default: begin
                            resp_next = make_out(RS_OK, ent_reg, 1'b1);
                        end
                    endcase
                end
                ram_wdata = e;
            end
            S_BACKOFF: begin
                if (bo_cnt_reg != '0) begin
                    bo_next     = (dbl > {1'b0, backoff_cap_reg}) ? backoff_cap_reg : dbl[31:0];
                    bo_cnt_next = bo_cnt_reg - 5'd1;
                end else begin
                    e.due      = sum[48] ? '1 : sum[47:0];
                    e.state    = ES_PENDING;
                    e.updated  = req_reg.now;
                    ram_we     = 1'b1;
                    ram_wdata  = e;
                    resp_next  = plain_out(RS_OK, '0);
                    state_next = S_RESP;
                end
            end
            S_ENQSCAN: begin
                if (rd_v && rd_ent.key == req_reg.key) begin
                    found_next = 1'b1;
                end
                if (rd_pend_reg && !valid_reg[rd_idx_reg] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                end
                if (scan_last) begin
                    state_next = S_ENQWRITE;
                end
            end
            S_ENQWRITE: begin
                state_next = S_RESP;
                e.key      = req_reg.key;
                e.record   = req_reg.record;
                e.state    = ES_PENDING;
                e.order    = order_ctr_reg;
                e.due      = req_reg.now;
                e.updated  = req_reg.now;
                e.tries    = '0;
                e.seq      = '0;
                ram_waddr  = free_idx_reg;
                ram_wdata  = e;
                if (found_reg) begin
                    resp_next = plain_out(RS_QUEUED, '0);
                end else if (!free_found_reg) begin
                    resp_next = plain_out(RS_FULL, '0);
                end else begin
                    ram_we                   = 1'b1;
                    valid_next[free_idx_reg] = 1'b1;
                    if (order_ctr_reg != '1) begin
                        order_ctr_next = order_ctr_reg + 32'd1;
                    end
                    resp_next = plain_out(RS_OK, '0);
                end
            end
            S_SWEEP: begin
                e         = rd_ent;
                e.due     = req_reg.now;
                e.state   = ES_PENDING;
                e.updated = req_reg.now;
                ram_waddr = rd_idx_reg;
                ram_wdata = e;
                if (rd_v) begin
                    if (req_reg.op == OP_RECOVER && rd_ent.state == ES_INFLIGHT) begin
                        ram_we = 1'b1;
                        if (cnt != '1) begin
                            cnt = cnt + 5'd1;
                        end
                    end else if (req_reg.op == OP_PRUNE && rd_ent.state == ES_APPLIED
                                 && rd_ent.updated < req_reg.cutoff) begin
                        valid_next[rd_idx_reg] = 1'b0;
                        if (cnt != '1) begin
                            cnt = cnt + 5'd1;
                        end
                    end
                end
                count_next = cnt;
                if (scan_last) begin
                    resp_next  = plain_out(RS_OK, cnt);
                    state_next = S_RESP;
                end
            end
            S_FIND: begin
                if (rd_v && (!prev_found_reg
                        || precedes(prev_order_reg, prev_idx_reg, rd_ent.order, rd_idx_reg))
                        && (!found_reg
                        || precedes(rd_ent.order, rd_idx_reg, ent_reg.order, slot_reg))) begin
                    f  = 1'b1;
                    sl = rd_idx_reg;
                    en = rd_ent;
                end
                found_next = f;
                slot_next  = sl;
                ent_next   = en;
                if (scan_last) begin
                    if (!f) begin
                        state_next = S_CDONE;
                    end else begin
                        prev_found_next = 1'b1;
                        prev_order_next = en.order;
                        prev_idx_next   = sl;
                        scan_on_next    = 1'b1;
                        scan_cnt_next   = '0;
                        found_next      = 1'b0;
                        blocked_next    = 1'b0;
                        if (en.state == ES_PENDING && en.due <= req_reg.now) begin
                            state_next = S_BLOCK;
                        end
                    end
                end
            end
            S_BLOCK: begin
                if (rd_v && precedes(rd_ent.order, rd_idx_reg, ent_reg.order, slot_reg)
                        && rd_ent.record == ent_reg.record && rd_ent.state != ES_APPLIED) begin
                    blk = 1'b1;
                end
                blocked_next = blk;
                if (scan_last) begin
                    if (blk) begin
                        scan_on_next  = 1'b1;
                        scan_cnt_next = '0;
                        state_next    = S_FIND;
                    end else begin
                        state_next = S_CLAIM;
                    end
                end
            end
            S_CLAIM: begin
                e.state   = ES_INFLIGHT;
                e.updated = req_reg.now;
                if (ent_reg.tries != '1) begin
                    e.tries = ent_reg.tries + 8'd1;
                end
                ram_wdata = e;
                if (claim_cnt_reg == '0 || out_free) begin
                    ram_we = 1'b1;
                    if (claim_cnt_reg != '0) begin
                        m_data_next  = held_reg;
                        m_valid_next = 1'b1;
                    end
                    held_next      = make_out(RS_OK, e, 1'b0);
                    claim_cnt_next = claim_cnt_reg + NW'(1);
                    if (claim_cnt_reg + NW'(1) == limit_reg) begin
                        state_next = S_CDONE;
                    end else begin
                        scan_on_next  = 1'b1;
                        scan_cnt_next = '0;
                        found_next    = 1'b0;
                        state_next    = S_FIND;
                    end
                end
            end
            S_CDONE: begin
                if (out_free) begin
                    if (claim_cnt_reg == '0) begin
                        m_data_next = plain_out(RS_NONE, '0);
                    end else begin
                        m_data_next      = held_reg;
                        m_data_next.last = 1'b1;
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_data_next  = resp_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        scan_cnt_reg   <= scan_cnt_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        ent_reg        <= ent_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        prev_found_reg <= prev_found_next;
        prev_order_reg <= prev_order_next;
        prev_idx_reg   <= prev_idx_next;
        blocked_reg    <= blocked_next;
        claim_cnt_reg  <= claim_cnt_next;
        limit_reg      <= limit_next;
        held_reg       <= held_next;
        count_reg      <= count_next;
        bo_reg         <= bo_next;
        bo_cnt_reg     <= bo_cnt_next;
        resp_reg       <= resp_next;
        m_data_reg     <= m_data_next;
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            attempt_limit_reg <= 8'd10;
            first_backoff_reg <= 32'd1000;
            backoff_cap_reg   <= 32'd300000;
            batch_min_reg     <= 5'd1;
            batch_max_reg     <= 5'd16;
            order_ctr_reg     <= 32'd1;
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
            scan_on_reg       <= 1'b0;
            rd_pend_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            attempt_limit_reg <= attempt_limit_next;
            first_backoff_reg <= first_backoff_next;
            backoff_cap_reg   <= backoff_cap_next;
            batch_min_reg     <= batch_min_next;
            batch_max_reg     <= batch_max_next;
            order_ctr_reg     <= order_ctr_next;
            valid_reg         <= valid_next;
            scan_on_reg       <= scan_on_next;
            rd_pend_reg       <= rd_pend_next;
            m_valid_reg       <= m_valid_next;
        end
    end
endmodule

[sv/oro_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module oro_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
